@@ hdl/q2r_pkg.sv @@
// shared types and constants for the quaternion to rotation matrix pipeline
`timescale 1ns / 1ps
package q2r_pkg;

  localparam int NumEnt  = 9;   // matrix entries
  localparam int QBits   = 16;  // quotient bits, one per divider stage
  localparam int SW      = 33;  // sum of squares width
  localparam int RW      = 34;  // partial remainder width
  localparam int NW      = 34;  // signed numerator width
  localparam int OneQ14  = 16384;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [QBits-1:0] quo;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic [SW-1:0]           s;
    div_lane_t [NumEnt-1:0]  lane;
  } div_stage_t;

  // one restoring step: compare, conditional subtract, shift
  function automatic div_lane_t div_step(input div_lane_t l, input logic [SW-1:0] s);
    div_lane_t     o;
    logic          ge;
    logic [RW-1:0] r;
    ge    = (l.rem >= {1'b0, s});
    r     = ge ? (l.rem - {1'b0, s}) : l.rem;
    o.rem = {r[RW-2:0], 1'b0};
    o.quo = {l.quo[QBits-2:0], ge};
    o.neg = l.neg;
    return o;
  endfunction

endpackage

@@ hdl/quaternion_to_rotation_matrix.sv @@
// quaternion to 3x3 rotation matrix, Q2.14 in and out, fully pipelined
`timescale 1ns / 1ps
// pipeline: 20 register stages (products, sums, magnitude, 16 divider stages, round and
//   clamp)
// throughput: one quaternion per cycle when the output is not stalled (pipelined divider)
// the whole pipeline holds while an output transaction is stalled
// rst is synchronous and active high; it clears the valid bits only
module quaternion_to_rotation_matrix (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // m_r0c0, m_r0c1, m_r0c2, m_r1c0 .. m_r2c2
  output logic         m_tuser    // zero_norm
);
  import q2r_pkg::*;

  // global advance: the output register is empty or being drained
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: squares and pair products
  logic               v1;
  logic signed [31:0] sw, sx, sy, sz, pxy, pzw, pxz, pyw, pyz, pxw;
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sw  <= qw * qw;
      sx  <= qx * qx;
      sy  <= qy * qy;
      sz  <= qz * qz;
      pxy <= qx * qy;
      pzw <= qz * qw;
      pxz <= qx * qz;
      pyw <= qy * qw;
      pyz <= qy * qz;
      pxw <= qx * qw;
    end
  end

  // stage 2: sum of squares and the nine numerators
  logic                 v2;
  logic [SW-1:0]        s2;
  logic signed [NW-1:0] n2 [NumEnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2    <= SW'($unsigned(sw)) + SW'($unsigned(sx)) + SW'($unsigned(sy))
             + SW'($unsigned(sz));
      n2[0] <= NW'(sx) - NW'(sy) - NW'(sz) + NW'(sw);
      n2[4] <= NW'(sy) - NW'(sx) - NW'(sz) + NW'(sw);
      n2[8] <= NW'(sz) - NW'(sx) - NW'(sy) + NW'(sw);
      // off-diagonal: twice a pair product sum or difference
      n2[3] <= (NW'(pxy) + NW'(pzw)) <<< 1;
      n2[1] <= (NW'(pxy) - NW'(pzw)) <<< 1;
      n2[6] <= (NW'(pxz) - NW'(pyw)) <<< 1;
      n2[2] <= (NW'(pxz) + NW'(pyw)) <<< 1;
      n2[7] <= (NW'(pyz) + NW'(pxw)) <<< 1;
      n2[5] <= (NW'(pyz) - NW'(pxw)) <<< 1;
    end
  end

  // stage 3: magnitudes and signs into the divider
  div_stage_t d_in, d_out;
  always_ff @(posedge clk) begin
    if (rst) begin
      d_in.valid <= 1'b0;
    end else if (en) begin
      d_in.valid <= v2;
      d_in.zero  <= (s2 == '0);
      d_in.s     <= s2;
      for (int i = 0; i < NumEnt; i++) begin
        d_in.lane[i].neg <= n2[i][NW-1];
        d_in.lane[i].rem <= RW'(n2[i][NW-1] ? -n2[i] : n2[i]);
        d_in.lane[i].quo <= '0;
      end
    end
  end

  // quotient is floor(|n| * 2^15 / s); |n| never exceeds s
  q2r_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (d_in),
    .dout (d_out)
  );

  // final stage: round half away from zero, clamp to 1.0, restore sign
  logic [15:0] ent [NumEnt];
  always_comb begin
    logic [15:0] q;
    for (int i = 0; i < NumEnt; i++) begin
      q = 16'(({1'b0, d_out.lane[i].quo} + 17'd1) >> 1);
      if (q > 16'(OneQ14)) q = 16'(OneQ14);
      if (d_out.lane[i].neg) q = -q;
      ent[i] = d_out.zero ? 16'd0 : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d_out.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NumEnt; i++) begin
        m_tdata[16*i +: 16] <= ent[i];
      end
      m_tuser <= d_out.zero;
    end
  end

endmodule

@@ hdl/q2r_divider.sv @@
// pipelined restoring divider, one quotient bit per stage for all entries
`timescale 1ns / 1ps
module q2r_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  q2r_pkg::div_stage_t   din,
  output q2r_pkg::div_stage_t   dout
);
  import q2r_pkg::*;

  div_stage_t stg [QBits+1];

  assign stg[0] = din;

  for (genvar k = 0; k < QBits; k++) begin : g_stage
    div_stage_t nxt;
    div_stage_t r;
    always_comb begin
      nxt = stg[k];
      for (int i = 0; i < NumEnt; i++) begin
        nxt.lane[i] = div_step(stg[k].lane[i], stg[k].s);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        r.valid <= 1'b0;
      end else if (en) begin
        r <= nxt;
      end
    end
    assign stg[k+1] = r;
  end

  assign dout = stg[QBits];

endmodule

@@ tb/sv/quaternion_to_rotation_matrix_tb.sv @@
// testbench for the quaternion to rotation matrix block: random and directed quaternions
`timescale 1ns / 1ps

// holds expected matrices in arrival order and compares each output against the oldest
class matrix_scoreboard;
  typedef struct {
    logic [15:0] ent [9];
    logic        zero;
  } matrix_t;

  matrix_t pending[$];
  int      errors;
  int      checked;
  int      zero_seen;

  // rounded n * 2^14 / s, half away from zero, clamped to +/-1.0
  static function logic [15:0] scaled_entry(longint n, longint unsigned s);
    longint unsigned mag;
    longint unsigned q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = (mag * 32768 + s) / (2 * s);
    if (q > 16384) q = 16384;
    if (n < 0) q = -q;
    return q[15:0];
  endfunction

  // works out the matrix for an accepted quaternion
  function void note_quaternion(logic signed [15:0] qw, logic signed [15:0] qx,
                                logic signed [15:0] qy, logic signed [15:0] qz);
    matrix_t m;
    longint w, x, y, z, sw, sx, sy, sz;
    longint unsigned s;
    longint n [9];
    w = qw; x = qx; y = qy; z = qz;
    sw = w * w; sx = x * x; sy = y * y; sz = z * z;
    s = sw + sx + sy + sz;
    if (s == 0) begin
      for (int i = 0; i < 9; i++) m.ent[i] = '0;
      m.zero = 1'b1;
    end else begin
      n[0] = sx - sy - sz + sw;
      n[4] = -sx + sy - sz + sw;
      n[8] = -sx - sy + sz + sw;
      n[3] = 2 * (x * y + z * w);
      n[1] = 2 * (x * y - z * w);
      n[6] = 2 * (x * z - y * w);
      n[2] = 2 * (x * z + y * w);
      n[7] = 2 * (y * z + x * w);
      n[5] = 2 * (y * z - x * w);
      for (int i = 0; i < 9; i++) m.ent[i] = scaled_entry(n[i], s);
      m.zero = 1'b0;
    end
    pending.push_back(m);
  endfunction

  function void check_matrix(logic [143:0] data, logic zero);
    matrix_t m;
    if (pending.size() == 0) begin
      $error("output transaction with no quaternion pending");
      errors++;
      return;
    end
    m = pending.pop_front();
    checked++;
    if (zero) zero_seen++;
    for (int i = 0; i < 9; i++)
      if (data[16*i +: 16] !== m.ent[i]) begin
        $error("m_r%0dc%0d expected %0d actual %0d", i / 3, i % 3,
               $signed(m.ent[i]), $signed(data[16*i +: 16]));
        errors++;
      end
    if (zero !== m.zero) begin
      $error("zero_norm expected %0b actual %0b", m.zero, zero);
      errors++;
    end
  endfunction
endclass

module quaternion_to_rotation_matrix_tb;
  localparam int RandomQuats = 450;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 40;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;  // quat_w, quat_x, quat_y, quat_z
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;       // m_r0c0 .. m_r2c2
  logic         m_tuser;       // zero_norm

  matrix_scoreboard sb = new();
  bit  sending_done = 1'b0;
  int  cycles = 0;
  int  sent = 0;

  quaternion_to_rotation_matrix DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // offer one quaternion, with a random gap before it
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_quaternion(w, x, y, z);
    sent++;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [15:0] ext [6];
    ext = '{16'h0000, 16'h4000, 16'hc000, 16'h7fff, 16'h8000, 16'h0001};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // zero quaternion, identity, axis rotations, extremes, tiny values
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'hffff, 16'h0000, 16'h0001);
    send_quat(16'h2d41, 16'h2d41, 16'h0000, 16'h0000);
    send_quat(16'h0001, 16'h0001, 16'hffff, 16'h0001);
    for (int i = 0; i < 10; i++)
      send_quat(ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)]);
    for (int i = 0; i < RandomQuats; i++)
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    s_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off early on to back up the pipeline
  initial begin
    int wait_cycles;
    @(negedge rst);
    repeat (15) @(posedge clk);
    m_tready <= 1'b0;
    repeat (80) @(posedge clk);
    forever begin
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // monitor: sample the output handshake at each rising edge
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_matrix(m_tdata, m_tuser);

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d quaternions, %0d matrices checked, %0d zero-norm cases",
             sent, sb.checked, sb.zero_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
